### rtl/accel_tilt_angle_core_assert.svh
// Assertion macros for the tilt angle core.
// Used by accel_tilt_angle_core; expects clk and rst_n in scope.
`ifndef ACCEL_TILT_ANGLE_CORE_ASSERT_SVH
`define ACCEL_TILT_ANGLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ATA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("tilt core assertion failed");
`define ATA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("tilt core assertion failed");
`else
`define ATA_ASSERT_IMP(lbl, ante, cons)
`define ATA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/atil_pkg.sv
// Shared types and constants for the tilt angle core.
// No dependencies.
package atil_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W;
  localparam int SQ_FRAC    = 8;
  localparam int RAD_W      = SUM_W + 2 * SQ_FRAC;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int OPND_W     = MAG_W + SQ_FRAC;
  localparam int SQRT_PER   = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_PER;

  localparam int ANG_STEPS  = 16;
  localparam int CORDIC_PER = 2;
  localparam int CORDIC_STAGES = ANG_STEPS / CORDIC_PER;
  localparam int CX_W       = OPND_W + 3;
  localparam int Z_W        = 19;
  localparam int ZM_W       = Z_W - 1;

  localparam int DEG_W      = 22;
  localparam logic [DEG_W-1:0] DEG_SCALE = DEG_W'(3756841);
  localparam int DEG_SHIFT  = 32;
  localparam int PROD_W     = ZM_W + DEG_W + 1;
  localparam int DEGI_W     = PROD_W - DEG_SHIFT;
  localparam logic [DEGI_W-1:0] DEG_MAX = DEGI_W'(90);

  localparam int LATENCY    = 2 + SQRT_STAGES + 1 + CORDIC_STAGES + 2;

  localparam logic signed [Z_W-1:0] ATAN_TAB [ANG_STEPS] = '{
    51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef enum logic [1:0] {
    OP_Z    = 2'd0,
    OP_X    = 2'd1,
    OP_Y    = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic [1:0]                 op;
  } in_t;

  typedef struct packed {
    logic signed [7:0] angle_deg;
    logic              degenerate;
  } out_t;

  typedef struct packed {
    logic              none;
    logic              neg;
    logic              root_num;
    logic [OPND_W-1:0] plain;
  } meta_t;

  typedef struct packed {
    logic none;
    logic neg;
    logic degen;
    logic zero;
    logic full;
  } flag_t;

endpackage

### rtl/atil_prep.sv
// Input stages: magnitudes, operand selection, squares, sum of squares.
// Depends on atil_pkg.
module atil_prep import atil_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_t              in_item,
  output logic             sum_valid,
  output logic [SUM_W-1:0] sum,
  output meta_t            sum_meta
);

  logic [MAG_W-1:0] mx, my, mz, ma, mb;
  logic [SQ_W-1:0]  sq_a_nxt, sq_b_nxt, sq_a_r, sq_b_r;
  meta_t            meta_nxt, meta1_r, meta2_r;
  logic             v1_r, v2_r;
  logic [SUM_W-1:0] sum_nxt, sum_r;

  always_comb begin
    mx = in_item.accel_x[SAMPLE_W-1] ? MAG_W'(-in_item.accel_x) : MAG_W'(in_item.accel_x);
    my = in_item.accel_y[SAMPLE_W-1] ? MAG_W'(-in_item.accel_y) : MAG_W'(in_item.accel_y);
    mz = in_item.accel_z[SAMPLE_W-1] ? MAG_W'(-in_item.accel_z) : MAG_W'(in_item.accel_z);
    meta_nxt.none     = 1'b0;
    meta_nxt.root_num = 1'b0;
    unique case (op_t'(in_item.op))
      OP_Z: begin
        ma = mx;
        mb = my;
        meta_nxt.plain    = {mz, {SQ_FRAC{1'b0}}};
        meta_nxt.neg      = in_item.accel_z[SAMPLE_W-1];
        meta_nxt.root_num = 1'b1;
      end
      OP_X: begin
        ma = my;
        mb = mz;
        meta_nxt.plain = {mx, {SQ_FRAC{1'b0}}};
        meta_nxt.neg   = in_item.accel_x[SAMPLE_W-1];
      end
      OP_Y: begin
        ma = mx;
        mb = mz;
        meta_nxt.plain = {my, {SQ_FRAC{1'b0}}};
        meta_nxt.neg   = in_item.accel_y[SAMPLE_W-1];
      end
      default: begin
        ma = '0;
        mb = '0;
        meta_nxt.plain = '0;
        meta_nxt.neg   = 1'b0;
        meta_nxt.none  = 1'b1;
      end
    endcase
    sq_a_nxt = SQ_W'(ma) * SQ_W'(ma);
    sq_b_nxt = SQ_W'(mb) * SQ_W'(mb);
    sum_nxt  = SUM_W'(sq_a_r) + SUM_W'(sq_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_a_r  <= sq_a_nxt;
    sq_b_r  <= sq_b_nxt;
    meta1_r <= meta_nxt;
    sum_r   <= sum_nxt;
    meta2_r <= meta1_r;
  end

  assign sum_valid = v2_r;
  assign sum       = sum_r;
  assign sum_meta  = meta2_r;

endmodule

### rtl/atil_sqrt.sv
// Pipelined digit-by-digit square root, two result bits per stage.
// Depends on atil_pkg.
module atil_sqrt import atil_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  logic [SUM_W-1:0]  s_val,
  input  meta_t             s_meta,
  output logic              r_valid,
  output logic [ROOT_W-1:0] r_root,
  output meta_t             r_meta
);

  logic [RAD_W-1:0]  rad_in   [SQRT_STAGES];
  logic [ROOT_W-1:0] root_in  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_in   [SQRT_STAGES];
  meta_t             meta_in  [SQRT_STAGES];
  logic              v_in     [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_nxt  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_nxt [SQRT_STAGES];
  logic [REM_W-1:0]  rem_nxt  [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_r    [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r   [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r    [SQRT_STAGES];
  meta_t             meta_r   [SQRT_STAGES];
  logic              v_r      [SQRT_STAGES];

  assign rad_in[0]  = {s_val, {(2 * SQ_FRAC){1'b0}}};
  assign root_in[0] = '0;
  assign rem_in[0]  = '0;
  assign meta_in[0] = s_meta;
  assign v_in[0]    = s_valid;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign rad_in[g]  = rad_r[g-1];
      assign root_in[g] = root_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign meta_in[g] = meta_r[g-1];
      assign v_in[g]    = v_r[g-1];
    end

    always_comb begin
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      logic [REM_W+1:0]  tmp;
      logic [REM_W+1:0]  trial;
      rad  = rad_in[g];
      root = root_in[g];
      rem  = rem_in[g];
      for (int t = 0; t < SQRT_PER; t++) begin
        tmp   = {rem, rad[RAD_W-1 -: 2]};
        rad   = rad << 2;
        trial = {2'b00, root, 2'b01};
        if (tmp >= trial) begin
          rem  = REM_W'(tmp - trial);
          root = {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  = REM_W'(tmp);
          root = {root[ROOT_W-2:0], 1'b0};
        end
      end
      rad_nxt[g]  = rad;
      root_nxt[g] = root;
      rem_nxt[g]  = rem;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      rad_r[g]  <= rad_nxt[g];
      root_r[g] <= root_nxt[g];
      rem_r[g]  <= rem_nxt[g];
      meta_r[g] <= meta_in[g];
    end
  end

  assign r_valid = v_r[SQRT_STAGES-1];
  assign r_root  = root_r[SQRT_STAGES-1];
  assign r_meta  = meta_r[SQRT_STAGES-1];

endmodule

### rtl/atil_cordic.sv
// Operand setup and pipelined vectoring CORDIC, two iterations per stage.
// Depends on atil_pkg.
module atil_cordic import atil_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  r_valid,
  input  logic [ROOT_W-1:0]     r_root,
  input  meta_t                 r_meta,
  output logic                  c_valid,
  output logic signed [Z_W-1:0] c_angle,
  output flag_t                 c_flags
);

  logic [OPND_W-1:0]     num, den;
  flag_t                 flg_nxt, flg0_r;
  logic signed [CX_W-1:0] x0_r, y0_r;
  logic                  v0_r;

  logic signed [CX_W-1:0] x_in [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_in [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_in [CORDIC_STAGES];
  flag_t                  f_in [CORDIC_STAGES];
  logic                   v_in [CORDIC_STAGES];
  logic signed [CX_W-1:0] x_nxt [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_nxt [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_nxt [CORDIC_STAGES];
  logic signed [CX_W-1:0] x_r [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_r [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_r [CORDIC_STAGES];
  flag_t                  f_r [CORDIC_STAGES];
  logic                   v_r [CORDIC_STAGES];

  always_comb begin
    num = r_meta.root_num ? r_root : r_meta.plain;
    den = r_meta.root_num ? r_meta.plain : r_root;
    flg_nxt.none  = r_meta.none;
    flg_nxt.neg   = r_meta.neg;
    flg_nxt.degen = (num == '0) && (den == '0);
    flg_nxt.zero  = (num == '0);
    flg_nxt.full  = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    x0_r   <= CX_W'(den);
    y0_r   <= CX_W'(num);
    flg0_r <= flg_nxt;
  end

  assign x_in[0] = x0_r;
  assign y_in[0] = y0_r;
  assign z_in[0] = '0;
  assign f_in[0] = flg0_r;
  assign v_in[0] = v0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign x_in[g] = x_r[g-1];
      assign y_in[g] = y_r[g-1];
      assign z_in[g] = z_r[g-1];
      assign f_in[g] = f_r[g-1];
      assign v_in[g] = v_r[g-1];
    end

    always_comb begin
      logic signed [CX_W-1:0] x, y, nx, ny;
      logic signed [Z_W-1:0]  z;
      x = x_in[g];
      y = y_in[g];
      z = z_in[g];
      for (int t = 0; t < CORDIC_PER; t++) begin
        if (y > 0) begin
          nx = x + (y >>> (g * CORDIC_PER + t));
          ny = y - (x >>> (g * CORDIC_PER + t));
          z  = z + ATAN_TAB[g * CORDIC_PER + t];
        end else if (y < 0) begin
          nx = x - (y >>> (g * CORDIC_PER + t));
          ny = y + (x >>> (g * CORDIC_PER + t));
          z  = z - ATAN_TAB[g * CORDIC_PER + t];
        end else begin
          nx = x;
          ny = y;
        end
        x = nx;
        y = ny;
      end
      x_nxt[g] = x;
      y_nxt[g] = y;
      z_nxt[g] = z;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      x_r[g] <= x_nxt[g];
      y_r[g] <= y_nxt[g];
      z_r[g] <= z_nxt[g];
      f_r[g] <= f_in[g];
    end
  end

  assign c_valid = v_r[CORDIC_STAGES-1];
  assign c_angle = z_r[CORDIC_STAGES-1];
  assign c_flags = f_r[CORDIC_STAGES-1];

endmodule

### rtl/accel_tilt_angle_core.sv
// Accelerometer tilt angle core, fully pipelined.
// Throughput: one transfer per cycle; busy stays low, the 12-stage root and
// 8-stage CORDIC pipelines set the depth. Synchronous active-low reset clears
// all valid bits; the receiver cannot stall. Depends on atil_pkg and submodules.
`include "accel_tilt_angle_core_assert.svh"
module accel_tilt_angle_core import atil_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic                  sum_valid, r_valid, c_valid;
  logic [SUM_W-1:0]      sum;
  meta_t                 sum_meta, r_meta;
  logic [ROOT_W-1:0]     r_root;
  logic signed [Z_W-1:0] c_angle;
  flag_t                 c_flags, f_m_r;

  logic [ZM_W-1:0]       zc;
  logic [PROD_W-1:0]     prod_nxt, prod_r;
  logic                  v_m_r, out_valid_r;
  logic [DEGI_W-1:0]     deg_i;
  logic [7:0]            mag;
  out_t                  out_nxt, out_r;

  assign busy = 1'b0;

  atil_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_data),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_meta  (sum_meta)
  );

  atil_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sum_valid),
    .s_val   (sum),
    .s_meta  (sum_meta),
    .r_valid (r_valid),
    .r_root  (r_root),
    .r_meta  (r_meta)
  );

  atil_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .r_valid (r_valid),
    .r_root  (r_root),
    .r_meta  (r_meta),
    .c_valid (c_valid),
    .c_angle (c_angle),
    .c_flags (c_flags)
  );

  always_comb begin
    zc       = c_angle[Z_W-1] ? '0 : c_angle[ZM_W-1:0];
    prod_nxt = PROD_W'(zc) * PROD_W'(DEG_SCALE);
    deg_i    = prod_r[PROD_W-1:DEG_SHIFT];
    priority if (f_m_r.none || f_m_r.zero) begin
      mag = 8'd0;
    end else if (f_m_r.full || deg_i > DEG_MAX) begin
      mag = 8'(DEG_MAX);
    end else begin
      mag = 8'(deg_i);
    end
    out_nxt.angle_deg  = f_m_r.neg ? -$signed(mag) : $signed(mag);
    out_nxt.degenerate = f_m_r.degen && !f_m_r.none;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_m_r       <= c_valid;
      out_valid_r <= v_m_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    f_m_r  <= c_flags;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ATA_ASSERT_IMP(a_latency, start && !busy, ##LATENCY out_valid)
  `ATA_ASSERT_IMP(a_range, out_valid, out_data.angle_deg <= 8'sd90 && out_data.angle_deg >= -8'sd90)
  `ATA_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, out_data.angle_deg == 8'sd0)
  `ATA_ASSERT_NXT(a_mult_to_out, v_m_r, out_valid)

endmodule

### sim/tb_accel_tilt_angle_core.sv
// Testbench for accel_tilt_angle_core: directed and random samples, every result
// checked in order against a fixed-point tilt angle predictor in a scoreboard class.
// Depends on atil_pkg and the RTL of accel_tilt_angle_core.
module tb_accel_tilt_angle_core;
  timeunit 1ns;
  timeprecision 1ps;
  import atil_pkg::*;

  localparam int N_RANDOM = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  int   n_errors = 0;

  always #1 clk = ~clk;

  accel_tilt_angle_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  class tilt_scoreboard;
    out_t expected_angles[$];

    static function longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
    endfunction

    static function longint root_q8(longint unsigned s);
      longint unsigned root, rem, pair, trial;
      root = 0;
      rem = 0;
      for (int k = 31 + SQ_FRAC; k >= 0; k--) begin
        pair = (k >= SQ_FRAC) ? ((s >> (2 * (k - SQ_FRAC))) & 3) : 0;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    static function longint cordic_deg(longint num, longint den);
      longint x, y, z, nx, ny;
      longint unsigned d;
      longint tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
      x = den;
      y = num;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        if (y == 0) break;
        if (y > 0) begin
          nx = x + floor_shift(y, i);
          ny = y - floor_shift(x, i);
          z += tab[i];
        end else begin
          nx = x - floor_shift(y, i);
          ny = y + floor_shift(x, i);
          z -= tab[i];
        end
        x = nx;
        y = ny;
      end
      if (z < 0) z = 0;
      d = (longint'(z) * 64'd3756841) >> 32;
      return (d > 90) ? 90 : longint'(d);
    endfunction

    static function out_t tilt_angle(in_t s);
      longint ax, ay, az, num, den, deg;
      logic neg;
      out_t r;
      ax = s.accel_x;
      ay = s.accel_y;
      az = s.accel_z;
      ax = ax < 0 ? -ax : ax;
      ay = ay < 0 ? -ay : ay;
      az = az < 0 ? -az : az;
      r = '0;
      neg = 1'b0;
      num = 0;
      den = 0;
      case (op_t'(s.op))
        OP_Z: begin
          num = root_q8(ax * ax + ay * ay);
          den = az << SQ_FRAC;
          neg = s.accel_z[SAMPLE_W-1];
        end
        OP_X: begin
          num = ax << SQ_FRAC;
          den = root_q8(ay * ay + az * az);
          neg = s.accel_x[SAMPLE_W-1];
        end
        OP_Y: begin
          num = ay << SQ_FRAC;
          den = root_q8(ax * ax + az * az);
          neg = s.accel_y[SAMPLE_W-1];
        end
        default: ;
      endcase
      if (op_t'(s.op) != OP_NONE) begin
        if (num == 0) begin
          deg = 0;
          r.degenerate = (den == 0);
        end else if (den == 0) begin
          deg = 90;
        end else begin
          deg = cordic_deg(num, den);
        end
        if (neg) deg = -deg;
        r.angle_deg = 8'(deg);
      end
      return r;
    endfunction

    function void note_transfer(in_t s);
      expected_angles.push_back(tilt_angle(s));
    endfunction

    task check_result(out_t got);
      out_t e;
      if (expected_angles.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = expected_angles.pop_front();
      if (got.angle_deg !== e.angle_deg)
        report_mismatch($sformatf("angle_deg got %0d expected %0d", got.angle_deg,
                                  e.angle_deg));
      if (got.degenerate !== e.degenerate)
        report_mismatch($sformatf("degenerate got %0b expected %0b", got.degenerate,
                                  e.degenerate));
    endtask
  endclass

  tilt_scoreboard sb = new();

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_transfer(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input op_t op, input bit may_idle);
    while (may_idle && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{accel_x: x, accel_y: y, accel_z: z, op: op};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'($urandom_range(2000) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edge_vals[6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                                  16'h4000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int o = 0; o < 4; o++) begin
      send_sample(16'h0000, 16'h0000, 16'h0000, op_t'(o), 1'b0);
      send_sample(16'h7fff, 16'h8000, 16'h0000, op_t'(o), 1'b0);
      send_sample(16'h0000, 16'h0000, 16'h8000, op_t'(o), 1'b0);
      send_sample(16'h8000, 16'h0000, 16'h0000, op_t'(o), 1'b0);
      send_sample(16'h0000, 16'h7fff, 16'h0001, op_t'(o), 1'b0);
    end
    for (int i = 0; i < 5; i++)
      send_sample(edge_vals[i], edge_vals[i+1], edge_vals[5-i], op_t'(i % 4), 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      send_sample(rand_sample(), rand_sample(), rand_sample(), op_t'($urandom_range(3)),
                  !(i >= 600 && i < 900));
    start <= 1'b0;
    while (sb.expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
